// ----- rtl/core/mfde_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_pkg
// shared constants and types for the monochrome framebuffer draw engine
// ----------------------------------------------------------------------------
package mfde_pkg;

    localparam int FB_BYTES_DEF   = 1024;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int CW = 12;

    typedef enum logic [2:0] {
        K_PIXEL = 3'd0,
        K_HRUN  = 3'd1,
        K_VRUN  = 3'd2,
        K_LINE  = 3'd3,
        K_READ  = 3'd4,
        K_CLEAR = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        M_CLR = 2'd0,
        M_SET = 2'd1,
        M_INV = 2'd2,
        M_NOP = 2'd3
    } t_mode;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // apply color mode to a byte under a mask
    function automatic logic [7:0] f_apply(input logic [7:0] d, input logic [7:0] m,
                                           input logic [1:0] mode);
        logic [7:0] r;
        begin
            case (mode)
                M_CLR:   r = d & ~m;
                M_SET:   r = d | m;
                M_INV:   r = d ^ m;
                default: r = d;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mfde_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/mono_framebuffer_draw_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// 1bpp page-organized framebuffer with pixel, run, line, read-back and clear
// ----------------------------------------------------------------------------
// Usage: commands enter on the i_ channel (i_valid / o_stall), one result
// per command leaves on the o_ channel (o_valid / i_stall). Config writes
// (panel width, panel height) use i_cfg_valid / o_cfg_ready, index 0 and 1.
// Every touched byte costs one read-modify-write step on the single frame
// memory (read, then modify and write). A pixel or read steps through
// setup, read and done; a horizontal run takes one step per clipped
// column, a vertical run one per page, a line one per point, and a clear
// writes one byte per cycle (FB_BYTES). After reset a clearing pass over
// all FB_BYTES bytes runs before the first command is taken. The result
// sits in an output register; while the receiver stalls it holds, and the
// next command is taken but its result waits until the register is free.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine
    import mfde_pkg::*;
#(
    parameter int FB_BYTES   = FB_BYTES_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [2:0]  i_kind,
    input  wire  [11:0] i_x_start,
    input  wire  [11:0] i_y_start,
    input  wire  [11:0] i_x_end,
    input  wire  [11:0] i_y_end,
    input  wire  [11:0] i_run_length,
    input  wire  [1:0]  i_color_mode,
    input  wire  [9:0]  i_byte_address,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_was_read,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    localparam int AW = $clog2(FB_BYTES);
    localparam int IW = 16;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_CLR   = 8'b0010_0000,
        S_RDB   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]  r_pw;
    logic [6:0]  r_ph;
    logic [AW:0] r_clr, n_clr;

    logic [2:0]  r_kind;
    logic [1:0]  r_mode;
    logic signed [IW-1:0] r_x, r_y, r_x1, r_y1, r_n, r_err, r_dx, r_dy;
    logic signed [IW-1:0] n_x, n_y, n_x1, n_y1, n_n, n_err, n_dx, n_dy;
    logic        r_steep, n_steep, r_ystep, n_ystep;
    logic [9:0]  r_addr;
    logic [7:0]  r_rd, n_rd;
    logic        r_isrd, n_isrd;
    logic        r_pend, n_pend;
    logic        r_ov, n_ov;
    logic [7:0]  r_od, n_od;
    logic        r_ow, n_ow;

    // current byte target
    logic        r_tv, n_tv;
    logic [AW:0] r_ta, n_ta;
    logic [7:0]  r_tm, n_tm;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  wdata, rdata;

    mfde_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic signed [IW-1:0] ew, eh;
    always_comb begin
        ew = (int'(r_pw) < MAX_WIDTH) ? IW'($signed({1'b0, r_pw})) : IW'(MAX_WIDTH);
        eh = (int'(r_ph) < MAX_HEIGHT) ? IW'($signed({1'b0, r_ph})) : IW'(MAX_HEIGHT);
    end

    // address of a pixel at (px, py), with in-range flag
    logic signed [IW-1:0] px, py;
    logic        pin;
    logic [IW+8:0] pidx;
    always_comb begin
        pin  = (px >= 0) && (px < ew) && (py >= 0) && (py < eh);
        pidx = (IW+9)'(unsigned'(px[IW-1:0])) +
               (IW+9)'(unsigned'(py[IW-1:3])) * (IW+9)'(unsigned'(ew[8:0]));
    end

    logic signed [IW-1:0] ax, ay, bx, by, adx, ady, lo, hi, last;

    assign o_stall     = !(r_state == S_IDLE) || r_pend;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_pend && !r_ov;
    assign o_valid     = r_ov;
    assign o_read_data = r_od;
    assign o_was_read  = r_ow;

    always_comb begin
        n_state = r_state; n_clr = r_clr;
        n_x = r_x; n_y = r_y; n_x1 = r_x1; n_y1 = r_y1; n_n = r_n;
        n_err = r_err; n_dx = r_dx; n_dy = r_dy;
        n_steep = r_steep; n_ystep = r_ystep;
        n_rd = r_rd; n_isrd = r_isrd; n_pend = r_pend;
        n_ov = r_ov; n_od = r_od; n_ow = r_ow;
        n_tv = r_tv; n_ta = r_ta; n_tm = r_tm;
        we = 1'b0; waddr = r_ta[AW-1:0]; wdata = '0; raddr = r_ta[AW-1:0];
        px = r_x; py = r_y;
        ax = '0; ay = '0; bx = '0; by = '0; adx = '0; ady = '0;
        lo = '0; hi = '0; last = '0;

        if (r_ov && !i_stall) n_ov = 1'b0;

        case (r_state)
            S_INIT, S_CLR: begin
                we = 1'b1; waddr = r_clr[AW-1:0]; wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(FB_BYTES - 1)) begin
                    n_clr = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_x  = IW'($signed(i_x_start));  n_y  = IW'($signed(i_y_start));
                    n_x1 = IW'($signed(i_x_end));    n_y1 = IW'($signed(i_y_end));
                    n_n  = IW'($signed(i_run_length));
                    n_isrd = 1'b0; n_rd = '0;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_DONE;
                n_tv = 1'b0;
                case (r_kind)
                    K_PIXEL: begin
                        n_tv = pin && (pidx < (IW+9)'(FB_BYTES));
                        n_ta = (AW+1)'(pidx);
                        n_tm = 8'(1 << r_y[2:0]);
                        n_state = n_tv ? S_RDB : S_DONE;
                    end
                    K_HRUN: begin
                        ax = r_x; bx = r_n;
                        if (ax < 0) begin bx = bx + ax; ax = '0; end
                        if (ax + bx > ew) bx = ew - ax;
                        n_x = ax; n_n = bx;
                        if (r_y >= 0 && r_y < eh && bx > 0) n_state = S_WR;
                    end
                    K_VRUN: begin
                        ay = r_y; by = r_n;
                        if (ay < 0) begin by = by + ay; ay = '0; end
                        if (ay + by > eh) by = eh - ay;
                        n_y = ay; n_y1 = ay + by - 1'b1;
                        if (r_x >= 0 && r_x < ew && by > 0) n_state = S_WR;
                    end
                    K_LINE: begin
                        adx = (r_x1 > r_x) ? r_x1 - r_x : r_x - r_x1;
                        ady = (r_y1 > r_y) ? r_y1 - r_y : r_y - r_y1;
                        n_steep = ady > adx;
                        ax = n_steep ? r_y : r_x;  ay = n_steep ? r_x : r_y;
                        bx = n_steep ? r_y1 : r_x1; by = n_steep ? r_x1 : r_y1;
                        if (ax > bx) begin
                            lo = ax; ax = bx; bx = lo;
                            lo = ay; ay = by; by = lo;
                        end
                        n_x = ax; n_y = ay; n_x1 = bx;
                        n_dx = bx - ax;
                        n_dy = (by > ay) ? by - ay : ay - by;
                        n_err = (bx - ax) >>> 1;
                        n_ystep = ay < by;
                        n_state = S_WR;
                    end
                    K_READ: begin
                        n_isrd = 1'b1;
                        n_tv = int'(r_addr) < FB_BYTES;
                        n_ta = (AW+1)'(r_addr);
                        n_state = n_tv ? S_RDB : S_DONE;
                    end
                    K_CLEAR: n_state = S_CLR;
                    default: n_state = S_DONE;
                endcase
            end
            S_RDB: begin
                // read issued from r_ta, data next cycle
                n_state = S_RD;
            end
            S_RD: begin
                // memory data for r_ta is valid now
                if (r_isrd) begin
                    n_rd = rdata;
                    n_state = S_DONE;
                end else begin
                    we = 1'b1; wdata = f_apply(rdata, r_tm, r_mode);
                    n_state = (r_kind == K_PIXEL) ? S_DONE : S_WR;
                end
            end
            S_WR: begin
                // choose the next byte; read it; modify in S_RD
                n_state = S_DONE;
                n_tv = 1'b0;
                case (r_kind)
                    K_HRUN: begin
                        px = r_x; py = r_y;
                        if (r_n > 0) begin
                            n_tv = pidx < (IW+9)'(FB_BYTES);
                            n_ta = (AW+1)'(pidx);
                            n_tm = 8'(1 << r_y[2:0]);
                            n_x = r_x + 1'b1; n_n = r_n - 1'b1;
                            n_state = S_WR;
                        end
                    end
                    K_VRUN: begin
                        px = r_x; py = r_y;
                        if (r_y <= r_y1) begin
                            lo = r_y;
                            hi = (r_y1 < {r_y[IW-1:3], 3'b111}) ? r_y1 : {r_y[IW-1:3], 3'b111};
                            n_tv = pidx < (IW+9)'(FB_BYTES);
                            n_ta = (AW+1)'(pidx);
                            n_tm = (8'hFF << lo[2:0]) & (8'hFF >> (3'd7 - hi[2:0]));
                            n_y = {r_y[IW-1:3], 3'b000} + 16'sd8;
                            n_state = S_WR;
                        end
                    end
                    default: begin
                        px = r_steep ? r_y : r_x; py = r_steep ? r_x : r_y;
                        if (r_x <= r_x1) begin
                            n_tv = pin && (pidx < (IW+9)'(FB_BYTES));
                            n_ta = (AW+1)'(pidx);
                            n_tm = 8'(1 << py[2:0]);
                            n_x = r_x + 1'b1;
                            last = r_err - r_dy;
                            if (last < 0) begin
                                n_y = r_ystep ? r_y + 1'b1 : r_y - 1'b1;
                                last = last + r_dx;
                            end
                            n_err = last;
                            n_state = S_WR;
                        end
                    end
                endcase
                if (n_tv && r_mode != M_NOP) begin
                    raddr = n_ta[AW-1:0];
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (!n_ov) begin
                    n_ov = 1'b1; n_od = r_rd; n_ow = r_isrd;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_RDB) raddr = r_ta[AW-1:0];
        n_pend = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_clr <= '0; r_pw <= 8'd128; r_ph <= 7'd64;
            r_ov <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_ov <= n_ov; r_pend <= n_pend;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) r_pw <= i_cfg_data;
                else r_ph <= i_cfg_data[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_x1 <= n_x1; r_y1 <= n_y1; r_n <= n_n;
        r_err <= n_err; r_dx <= n_dx; r_dy <= n_dy;
        r_steep <= n_steep; r_ystep <= n_ystep;
        r_rd <= n_rd; r_isrd <= n_isrd; r_od <= n_od; r_ow <= n_ow;
        r_tv <= n_tv; r_ta <= n_ta; r_tm <= n_tm;
        if (r_state == S_IDLE && i_valid && !o_stall) begin
            r_kind <= i_kind; r_mode <= i_color_mode; r_addr <= i_byte_address;
        end
    end

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_was_read |-> o_read_data == 8'd0) else $error("ack data");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall) else $error("busy take");
    a_clr_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INIT |-> !o_valid) else $error("result in init");
endmodule
`default_nettype wire
